FILE: rtl/core/bmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared constants, codes and types of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

	localparam int DEPTH_DEF    = 1024;
	localparam int KEY_BITS_DEF = 31;

	localparam int CFG_W     = 11;
	localparam int CNT_OUT_W = 11;
	localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_CAP = 1'b0;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
	} res_ctl_t;

endpackage

FILE: rtl/core/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue: insert, delete-min and find-min on unsigned keys.
// ----------------------------------------------------------------------------
// Usage
//   A request (op, key) is taken at a clock edge with start high and busy low.
//   Exactly one result follows: done is high for one cycle with min_key,
//   status and count, and must be taken in that cycle.
//   Full and empty requests are answered in the next cycle and never raise busy.
//   Find-min reads the root in S_RT_RD and answers through the result register.
//   Insert lifts the key L levels, up to log2 of the count, with one store read
//   and one compare per level.
//   Delete-min sinks the last key L levels; each level reads the children
//   through the single store read port and uses the one comparator twice,
//   or once where a node has only a left child.
//   A new request may start in the cycle its predecessor's done is shown.
//   Reset empties the heap and sets the capacity limit to 1024; the store
//   itself is not cleared, as slots are written before they are read.
//   The capacity limit sits at APB address 0; the user must write it only while idle, unchecked by the block.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
	import bmh_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           op,
	input  logic [KEY_BITS-1:0]  key,
	output logic                 done,
	output logic [KEY_BITS-1:0]  min_key,
	output logic [1:0]           status,
	output logic [CNT_OUT_W-1:0] count,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int CX_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

	logic [CFG_W-1:0]    cap;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [KEY_BITS-1:0] ram_wdata, ram_rdata;
	res_ctl_t            res_ctl;
	logic [KEY_BITS-1:0] res_key;
	logic [CNT_W-1:0]    res_count;
	logic [CX_W-1:0]     cnt_x;

	logic                 done_q;
	logic [KEY_BITS-1:0]  min_key_q;
	logic [1:0]           status_q;
	logic [CNT_OUT_W-1:0] count_q;

	bmh_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap)
	);

	bmh_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bmh_seq #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.key       (key),
		.cap       (cap),
		.busy      (busy),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_ctl   (res_ctl),
		.res_key   (res_key),
		.res_count (res_count)
	);

	// result beat register
	assign cnt_x = CX_W'(res_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ctl.valid) begin
			min_key_q <= res_key;
			status_q  <= res_ctl.status;
			count_q   <= cnt_x[CNT_OUT_W-1:0];
		end
	end

	assign done    = done_q;
	assign min_key = min_key_q;
	assign status  = status_q;
	assign count   = count_q;

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sift ended without a result beat");

	a_empty_req: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != OP_INSERT && res_count == '0)
		|=> (done && status == ST_EMPTY && min_key == '0))
		else $error("request on empty heap not answered as empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, res_count} <= (CNT_W+1)'(DEPTH))
		else $error("key count beyond store depth");

endmodule

FILE: rtl/core/bmh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmh_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/bmh_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_apb
// APB register slice holding the capacity limit.
// ----------------------------------------------------------------------------
module bmh_apb
	import bmh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CFG_W-1:0]  cap
);

	logic             reg_idx;
	logic             wr_beat;
	logic [CFG_W-1:0] cap_q;

	assign reg_idx = paddr[2];
	assign wr_beat = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cap     = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_beat && reg_idx == REG_CAP) begin
			cap_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAP: prdata = APB_DW'(cap_q);
			default: prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/bmh_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_seq
// Sift sequencer: walks the heap one level at a time through a single
// key comparator and the store's one read and one write port.
// ----------------------------------------------------------------------------
module bmh_seq
	import bmh_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   op,
	input  logic [KEY_BITS-1:0]          key,
	input  logic [CFG_W-1:0]             cap,
	output logic                         busy,
	output logic                         ram_we,
	output logic [$clog2(DEPTH)-1:0]     ram_waddr,
	output logic [KEY_BITS-1:0]          ram_wdata,
	output logic [$clog2(DEPTH)-1:0]     ram_raddr,
	input  logic [KEY_BITS-1:0]          ram_rdata,
	output res_ctl_t                     res_ctl,
	output logic [KEY_BITS-1:0]          res_key,
	output logic [$clog2(DEPTH+1)-1:0]   res_count
);

	localparam int AW     = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH+1);
	localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int IDX2_W = CNT_W + 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_RD  = 4'd1;
	localparam logic [3:0] S_INS_CMP = 4'd2;
	localparam logic [3:0] S_RT_RD   = 4'd3;
	localparam logic [3:0] S_LAST    = 4'd4;
	localparam logic [3:0] S_DL_RD   = 4'd5;
	localparam logic [3:0] S_DL_RR   = 4'd6;
	localparam logic [3:0] S_DL_SEL  = 4'd7;
	localparam logic [3:0] S_DL_DEC  = 4'd8;

	logic [3:0]          state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    idx_q, cidx_q;
	logic [KEY_BITS-1:0] x_q, top_q, child_q;
	logic [1:0]          op_q;

	logic [KEY_BITS-1:0] cmp_a, cmp_b;
	logic                lt;
	logic                full;
	logic [IDX2_W-1:0]   c2, c2p1;

	function automatic logic [AW-1:0] slot(input logic [CNT_W-1:0] i);
		logic [CNT_W-1:0] j;
		j = i - CNT_W'(1);
		return j[AW-1:0];
	endfunction

	assign lt   = cmp_a < cmp_b;
	assign full = (LIM_W'(count_q) >= LIM_W'(cap)) || (LIM_W'(count_q) >= LIM_W'(DEPTH));
	assign c2   = {idx_q, 1'b0};
	assign c2p1 = {idx_q, 1'b1};
	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_waddr = slot(idx_q);
		ram_wdata = x_q;
		ram_raddr = slot(CNT_W'(1));
		cmp_a     = x_q;
		cmp_b     = ram_rdata;
		res_ctl   = '{valid: 1'b0, status: ST_OK};
		res_key   = '0;
		res_count = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (op == OP_INSERT) begin
						if (full) begin
							res_ctl = '{valid: 1'b1, status: ST_FULL};
						end else begin
							count_d = count_q + CNT_W'(1);
							state_d = S_INS_RD;
						end
					end else if (count_q == '0) begin
						res_ctl = '{valid: 1'b1, status: ST_EMPTY};
					end else begin
						state_d = S_RT_RD;
					end
				end
			end
			S_INS_RD: begin
				if (idx_q == CNT_W'(1)) begin
					ram_we  = 1'b1;
					res_ctl = '{valid: 1'b1, status: ST_OK};
					state_d = S_IDLE;
				end else begin
					ram_raddr = slot(idx_q >> 1);
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				ram_we = 1'b1;
				if (lt) begin
					ram_wdata = ram_rdata;
					state_d   = S_INS_RD;
				end else begin
					res_ctl = '{valid: 1'b1, status: ST_OK};
					state_d = S_IDLE;
				end
			end
			S_RT_RD: begin
				if (op_q == OP_DELETE) begin
					ram_raddr = slot(count_q);
					state_d   = S_LAST;
				end else begin
					res_ctl = '{valid: 1'b1, status: ST_OK};
					res_key = ram_rdata;
					state_d = S_IDLE;
				end
			end
			S_LAST: begin
				count_d = count_q - CNT_W'(1);
				state_d = S_DL_RD;
			end
			S_DL_RD: begin
				if (c2 > IDX2_W'(count_q)) begin
					ram_we  = 1'b1;
					res_ctl = '{valid: 1'b1, status: ST_OK};
					res_key = top_q;
					state_d = S_IDLE;
				end else begin
					ram_raddr = slot(c2[CNT_W-1:0]);
					state_d   = S_DL_RR;
				end
			end
			S_DL_RR: begin
				if (c2 != IDX2_W'(count_q)) begin
					ram_raddr = slot(c2p1[CNT_W-1:0]);
					state_d   = S_DL_SEL;
				end else begin
					state_d = S_DL_DEC;
				end
			end
			S_DL_SEL: begin
				cmp_a   = ram_rdata;
				cmp_b   = child_q;
				state_d = S_DL_DEC;
			end
			S_DL_DEC: begin
				cmp_a  = child_q;
				cmp_b  = x_q;
				ram_we = 1'b1;
				if (lt) begin
					ram_wdata = child_q;
					state_d   = S_DL_RD;
				end else begin
					res_ctl = '{valid: 1'b1, status: ST_OK};
					res_key = top_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					x_q   <= key;
					op_q  <= op;
					idx_q <= count_q + CNT_W'(1);
				end
			end
			S_INS_CMP: begin
				if (lt) begin
					idx_q <= idx_q >> 1;
				end
			end
			S_RT_RD: begin
				top_q <= ram_rdata;
			end
			S_LAST: begin
				x_q   <= ram_rdata;
				idx_q <= CNT_W'(1);
			end
			S_DL_RR: begin
				child_q <= ram_rdata;
				cidx_q  <= c2[CNT_W-1:0];
			end
			S_DL_SEL: begin
				if (lt) begin
					child_q <= ram_rdata;
					cidx_q  <= cidx_q + CNT_W'(1);
				end
			end
			S_DL_DEC: begin
				if (lt) begin
					idx_q <= cidx_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
